// ===== design/tpm_ma_pkg.sv =====
// Shared widths, constants, codes and state types of the throughput meter.
`default_nettype none

package tpm_ma_pkg;

    // Field and state widths.
    localparam int BYTES_W    = 24;
    localparam int ACC_W      = 40;
    localparam int RATE_W     = 40;
    localparam int TICK_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int WINDOW_W   = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 1'b1;

    // Reset values of the registers.
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 7'd0;

    // Request kinds carried in tuser.
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Bytes per interval to bits per second: 8 bits times 1000 ms.
    localparam int BIT_MS_W = 14;
    localparam logic [BIT_MS_W-1:0] BYTES_TO_BIT_MS = 14'd8000;
    localparam int SCALED_W = ACC_W + BIT_MS_W;

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    // Serial divider: the widest dividend is tick count times mean plus a rate.
    localparam int DIV_W     = TICK_W + RATE_W + 1;
    localparam int DEN_W     = TICK_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int WINDOW_DEPTH_DEFAULT = 64;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_READ,
        S_UPDATE
    } state_t;

    // What the running division is for.
    typedef enum logic [1:0] {
        DIV_RATE,
        DIV_IDX,
        DIV_CUM,
        DIV_MOV
    } div_op_t;

endpackage

`default_nettype wire

// ===== design/tpm_ma_ram.sv =====
// Generic single-port-write, registered-read synchronous RAM.
`default_nettype none

module tpm_ma_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/throughput_meter_moving_average_core.sv =====
// Throughput meter: byte counting, rate per interval and cumulative or moving mean rate.
//
// Frame requests (tuser low) add their byte count to a saturating 40-bit accumulator
// and are taken one per cycle. A tick request (tuser high) turns the count into
// bits per second, clears it and updates the mean; the block then takes no request
// until the result has been loaded into the output register. The tick work runs
// through one shared restoring divider that retires one quotient bit per cycle; its
// final step of the mean division waits while the result register is full. A tick
// in cumulative mode runs two divisions and a two-step multiply before the next
// request is taken, in moving-average mode three divisions (the second of which
// finds the window slot) plus a read and a write of the window store. After reset
// the window store is cleared one entry per cycle, during which no request is
// taken; configuration writes are accepted at any time but must only be made
// while the block is idle.
`default_nettype none

module throughput_meter_moving_average_core #(
    parameter int WINDOW_DEPTH = tpm_ma_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [tpm_ma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpm_ma_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Request channel.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [23:0]                       s_tdata,  // [23:0] frame_bytes
    input  wire logic                              s_tuser,  // [0] opcode
    // Result channel.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [79:0]                            m_tdata   // [39:0] rate_bps,
                                                             // [79:40] mean_rate_bps
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W = tpm_ma_pkg::RATE_W + $clog2(WINDOW_DEPTH) + 1;
    localparam int ACC_W = tpm_ma_pkg::ACC_W;
    localparam int RATE_W = tpm_ma_pkg::RATE_W;
    localparam int TICK_W = tpm_ma_pkg::TICK_W;
    localparam int DIV_W = tpm_ma_pkg::DIV_W;
    localparam int DEN_W = tpm_ma_pkg::DEN_W;

    // Control state.
    tpm_ma_pkg::state_t state_reg, state_next;
    logic [tpm_ma_pkg::INTERVAL_W-1:0] interval_reg;
    logic [tpm_ma_pkg::WINDOW_W-1:0]   window_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [RATE_W-1:0] mean_reg, mean_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Payload and datapath registers.
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [63:0]       prod_lo_reg, prod_lo_next;
    logic [RATE_W-1:0] prod_hi_reg, prod_hi_next;
    logic [DIV_W-1:0]  div_quo_reg, div_quo_next;
    logic [DEN_W-1:0]  div_rem_reg, div_rem_next;
    logic [DEN_W-1:0]  div_den_reg, div_den_next;
    logic [tpm_ma_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    tpm_ma_pkg::div_op_t div_op_reg, div_op_next;
    logic [RATE_W-1:0] m_rate_reg, m_rate_next;
    logic [RATE_W-1:0] m_mean_reg, m_mean_next;

    // Window store.
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [RATE_W-1:0] ram_wdata;
    logic [RATE_W-1:0] ram_rdata;

    // Combinational helpers.
    logic [DEN_W-1:0]  eff_win;
    logic [DEN_W:0]    div_trial;
    logic [DEN_W:0]    div_diff;
    logic              div_fit;
    logic [DIV_W-1:0]  quo_step;
    logic [DEN_W-1:0]  rem_step;
    logic [ACC_W:0]    acc_sum;
    logic [tpm_ma_pkg::SCALED_W-1:0] acc_scaled;
    logic [SUM_W-1:0]  sum_upd;

    tpm_ma_ram #(
        .WIDTH (RATE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Window length limited to the store depth.
    assign eff_win = (DEN_W'(window_reg) > DEN_W'(WINDOW_DEPTH)) ?
                     DEN_W'(WINDOW_DEPTH) : DEN_W'(window_reg);

    // One restoring division step.
    assign div_trial = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_fit   = div_trial >= {1'b0, div_den_reg};
    assign div_diff  = div_trial - {1'b0, div_den_reg};
    assign rem_step  = div_fit ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
    assign quo_step  = {div_quo_reg[DIV_W-2:0], div_fit};

    // Frame accumulation and tick scaling.
    assign acc_sum    = {1'b0, acc_reg} + (ACC_W + 1)'(s_tdata);
    assign acc_scaled = tpm_ma_pkg::SCALED_W'(acc_reg) *
                        tpm_ma_pkg::SCALED_W'(tpm_ma_pkg::BYTES_TO_BIT_MS);

    // Running window sum with the oldest entry swapped for the new rate.
    assign sum_upd = sum_reg - SUM_W'(ram_rdata) + SUM_W'(rate_reg);

    assign s_tready = (state_reg == tpm_ma_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_mean_reg, m_rate_reg};

    // Sequencer: next state and datapath values.
    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        tick_next     = tick_reg;
        mean_next     = mean_reg;
        sum_next      = sum_reg;
        clr_cnt_next  = clr_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        rate_next     = rate_reg;
        idx_next      = idx_reg;
        prod_lo_next  = prod_lo_reg;
        prod_hi_next  = prod_hi_reg;
        div_quo_next  = div_quo_reg;
        div_rem_next  = div_rem_reg;
        div_den_next  = div_den_reg;
        div_cnt_next  = div_cnt_reg;
        div_op_next   = div_op_reg;
        m_rate_next   = m_rate_reg;
        m_mean_next   = m_mean_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = rate_reg;

        // The result register empties when the downstream takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            tpm_ma_pkg::S_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(WINDOW_DEPTH - 1)) begin
                    state_next = tpm_ma_pkg::S_IDLE;
                end
            end

            tpm_ma_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == tpm_ma_pkg::OP_TICK) begin
                        // Start the rate division and clear the byte count.
                        div_quo_next = DIV_W'(acc_scaled);
                        div_rem_next = '0;
                        div_den_next = (interval_reg == '0) ? DEN_W'(1) :
                                       DEN_W'(interval_reg);
                        div_cnt_next = tpm_ma_pkg::DIV_CNT_W'(DIV_W);
                        div_op_next  = tpm_ma_pkg::DIV_RATE;
                        acc_next     = '0;
                        state_next   = tpm_ma_pkg::S_DIV;
                    end else begin
                        acc_next = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
                    end
                end
            end

            tpm_ma_pkg::S_DIV: begin
                div_quo_next = quo_step;
                div_rem_next = rem_step;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == tpm_ma_pkg::DIV_CNT_W'(1)) begin
                    case (div_op_reg)
                        tpm_ma_pkg::DIV_RATE: begin
                            rate_next = (|quo_step[DIV_W-1:RATE_W]) ?
                                        tpm_ma_pkg::RATE_MAX : quo_step[RATE_W-1:0];
                            if (window_reg == '0) begin
                                state_next = tpm_ma_pkg::S_MUL_LO;
                            end else begin
                                // Window slot is the tick count modulo the window.
                                div_quo_next = DIV_W'(tick_reg);
                                div_rem_next = '0;
                                div_den_next = eff_win;
                                div_cnt_next = tpm_ma_pkg::DIV_CNT_W'(DIV_W);
                                div_op_next  = tpm_ma_pkg::DIV_IDX;
                            end
                        end
                        tpm_ma_pkg::DIV_IDX: begin
                            idx_next   = rem_step[IDX_W-1:0];
                            state_next = tpm_ma_pkg::S_READ;
                        end
                        default: begin
                            // Cumulative or moving mean is complete.
                            mean_next  = quo_step[RATE_W-1:0];
                            state_next = tpm_ma_pkg::S_UPDATE;
                            if (!m_tvalid_reg || m_tready) begin
                                m_tvalid_next = 1'b1;
                                m_rate_next   = rate_reg;
                                m_mean_next   = quo_step[RATE_W-1:0];
                                tick_next     = tick_reg + 1'b1;
                                state_next    = tpm_ma_pkg::S_IDLE;
                            end else begin
                                // Hold here until the result register is free.
                                div_cnt_next = div_cnt_reg;
                                div_quo_next = div_quo_reg;
                                div_rem_next = div_rem_reg;
                                mean_next    = mean_reg;
                                state_next   = tpm_ma_pkg::S_DIV;
                            end
                        end
                    endcase
                end
            end

            tpm_ma_pkg::S_MUL_LO: begin
                prod_lo_next = 64'(tick_reg) * 64'(mean_reg[31:0]);
                state_next   = tpm_ma_pkg::S_MUL_HI;
            end

            tpm_ma_pkg::S_MUL_HI: begin
                prod_hi_next = RATE_W'(tick_reg) * RATE_W'(mean_reg[RATE_W-1:32]);
                state_next   = tpm_ma_pkg::S_SUM;
            end

            tpm_ma_pkg::S_SUM: begin
                // Dividend (n - 1) * mean + rate over n = tick count + 1.
                div_quo_next = DIV_W'(prod_lo_reg) + {1'b0, prod_hi_reg, 32'b0} +
                               DIV_W'(rate_reg);
                div_rem_next = '0;
                div_den_next = DEN_W'(tick_reg) + 1'b1;
                div_cnt_next = tpm_ma_pkg::DIV_CNT_W'(DIV_W);
                div_op_next  = tpm_ma_pkg::DIV_CUM;
                state_next   = tpm_ma_pkg::S_DIV;
            end

            tpm_ma_pkg::S_READ: begin
                // Store read of the oldest rate is under way.
                state_next = tpm_ma_pkg::S_UPDATE;
            end

            tpm_ma_pkg::S_UPDATE: begin
                ram_we       = 1'b1;
                sum_next     = sum_upd;
                div_quo_next = DIV_W'(sum_upd);
                div_rem_next = '0;
                div_den_next = eff_win;
                div_cnt_next = tpm_ma_pkg::DIV_CNT_W'(DIV_W);
                div_op_next  = tpm_ma_pkg::DIV_MOV;
                state_next   = tpm_ma_pkg::S_DIV;
            end

            default: begin
                state_next = tpm_ma_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tpm_ma_pkg::S_CLEAR;
            interval_reg <= tpm_ma_pkg::INTERVAL_RESET;
            window_reg   <= tpm_ma_pkg::WINDOW_RESET;
            acc_reg      <= '0;
            tick_reg     <= '0;
            mean_reg     <= '0;
            sum_reg      <= '0;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            tick_reg     <= tick_next;
            mean_reg     <= mean_next;
            sum_reg      <= sum_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    tpm_ma_pkg::CFG_INTERVAL: begin
                        interval_reg <= cfg_wdata[tpm_ma_pkg::INTERVAL_W-1:0];
                    end
                    tpm_ma_pkg::CFG_WINDOW: begin
                        window_reg <= cfg_wdata[tpm_ma_pkg::WINDOW_W-1:0];
                    end
                    default: begin
                        window_reg <= window_reg;
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rate_reg    <= rate_next;
        idx_reg     <= idx_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        div_quo_reg <= div_quo_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_cnt_reg <= div_cnt_next;
        div_op_reg  <= div_op_next;
        m_rate_reg  <= m_rate_next;
        m_mean_reg  <= m_mean_next;
    end

`ifndef SYNTHESIS
    // A tick clears the byte count and makes the block busy.
    a_tick_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == tpm_ma_pkg::OP_TICK)
        |=> (acc_reg == '0 && !s_tready))
        else $error("tick did not clear the byte count or left the block ready");

    // A frame never lowers the byte count.
    a_frame_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == tpm_ma_pkg::OP_FRAME)
        |=> (acc_reg >= $past(acc_reg)))
        else $error("frame lowered the byte count");

    // The window store is written only by the clearing pass or a window update.
    a_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == tpm_ma_pkg::S_CLEAR || state_reg == tpm_ma_pkg::S_UPDATE))
        else $error("window store written outside clear or update");

    // No result appears while the store is being cleared.
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tpm_ma_pkg::S_CLEAR) |-> (!m_tvalid_reg && !s_tready))
        else $error("activity during the clearing pass");

    // A result is loaded only together with a tick count step.
    a_result_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg && !m_tready)) |-> (tick_reg != $past(tick_reg)))
        else $error("result loaded without a tick count step");
`endif

endmodule

`default_nettype wire

// ===== bench/throughput_rate_checker.sv =====
// Checker for the throughput meter: predicts every tick result and compares it with the output.
module throughput_rate_checker
    import tpm_ma_pkg::*;
#(
    parameter int WINDOW_SLOTS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [23:0] frame_bytes
    input  logic                  s_tuser,   // [0] opcode
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [79:0]           m_tdata,   // [39:0] rate_bps, [79:40] mean_rate_bps
    output int                    error_count,
    output int                    pending_results,
    output int                    results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // One tick result, laid out as on the result bus.
    typedef struct packed {
        logic [RATE_W-1:0] mean_rate;
        logic [RATE_W-1:0] rate;
    } rate_pair_t;

    // Shadow registers and the meter's own state.
    logic [INTERVAL_W-1:0] interval_reg;
    logic [WINDOW_W-1:0]   window_reg;
    logic [ACC_W-1:0]      byte_total;
    logic [TICK_W-1:0]     tick_total;
    logic [RATE_W-1:0]     mean_last;
    logic [46:0]           window_total;
    logic [RATE_W-1:0]     rate_hist [WINDOW_SLOTS];

    rate_pair_t expected_rates [$];

    // Closes the current interval: works out the rate, clears the byte count and
    // updates the cumulative or windowed mean.
    function automatic rate_pair_t close_interval();
        logic [63:0]   divisor;
        logic [63:0]   scaled;
        logic [79:0]   weighted;
        logic [6:0]    span;
        int unsigned   slot;
        rate_pair_t    res;
        divisor = (interval_reg == '0) ? 64'd1 : 64'(interval_reg);
        scaled  = (64'(byte_total) * 64'd8000) / divisor;
        res.rate = (scaled > 64'(RATE_MAX)) ? RATE_MAX : scaled[RATE_W-1:0];
        byte_total = '0;
        if (window_reg == '0) begin
            // Cumulative mean, the first tick counting as one.
            weighted = 80'(tick_total) * 80'(mean_last) + 80'(res.rate);
            weighted = weighted / (80'(tick_total) + 80'd1);
            mean_last = weighted[RATE_W-1:0];
        end else begin
            // Windows longer than the store act as the full store.
            span = (window_reg > WINDOW_SLOTS) ? 7'(WINDOW_SLOTS) : window_reg;
            slot = tick_total % span;
            window_total = window_total - 47'(rate_hist[slot]) + 47'(res.rate);
            rate_hist[slot] = res.rate;
            mean_last = 40'(window_total / span);
        end
        tick_total = tick_total + 1'b1;
        res.mean_rate = mean_last;
        return res;
    endfunction

    // Follow the register writes and requests, and check every delivered result.
    always @(posedge aclk) begin
        rate_pair_t seen;
        rate_pair_t want;
        logic [ACC_W:0] sum;
        if (!aresetn) begin
            interval_reg = INTERVAL_RESET;
            window_reg   = WINDOW_RESET;
            byte_total   = '0;
            tick_total   = '0;
            mean_last    = '0;
            window_total = '0;
            foreach (rate_hist[i]) rate_hist[i] = '0;
            expected_rates.delete();
        end else begin
            // A delivered result is matched against the oldest prediction.
            if (m_tvalid && m_tready) begin
                seen = rate_pair_t'(m_tdata);
                if (expected_rates.size() == 0) begin
                    $display("%0t: result with no prediction waiting: rate_bps %0d, mean_rate_bps %0d",
                             $time, seen.rate, seen.mean_rate);
                    error_count++;
                end else begin
                    want = expected_rates.pop_front();
                    results_checked++;
                    if (seen.rate !== want.rate) begin
                        $display("%0t: rate_bps mismatch, expected %0d, actual %0d",
                                 $time, want.rate, seen.rate);
                        error_count++;
                    end
                    if (seen.mean_rate !== want.mean_rate) begin
                        $display("%0t: mean_rate_bps mismatch, expected %0d, actual %0d",
                                 $time, want.mean_rate, seen.mean_rate);
                        error_count++;
                    end
                end
            end

            if (cfg_we) begin
                case (cfg_index)
                    CFG_INTERVAL: interval_reg = cfg_wdata[INTERVAL_W-1:0];
                    CFG_WINDOW:   window_reg   = cfg_wdata[WINDOW_W-1:0];
                    default: ;
                endcase
            end

            // A frame adds to the saturating byte count; a tick yields one result.
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_TICK) begin
                    expected_rates.push_back(close_interval());
                end else begin
                    sum = 41'(byte_total) + 41'(s_tdata);
                    byte_total = sum[ACC_W] ? RATE_MAX : sum[ACC_W-1:0];
                end
            end
        end
        pending_results = expected_rates.size();
    end

endmodule

// ===== bench/throughput_meter_moving_average_core_tb.sv =====
// Testbench top for the throughput meter: clock, reset, stimulus and the final verdict.
module throughput_meter_moving_average_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpm_ma_pkg::*;

    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int SETTLE_CYCLES    = 250;
    localparam int END_CYCLES       = 300;
    localparam int RECV_HOLD_CYCLES = 2000;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [79:0]           m_tdata;

    int error_count;
    int pending_results;
    int results_checked;

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_requests;
    int holds_served;
    int requests_sent;
    int ticks_sent;
    int settings_applied;
    int idle_cycles;

    throughput_meter_moving_average_core #(
        .WINDOW_DEPTH (64)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    throughput_rate_checker #(
        .WINDOW_SLOTS (64)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .error_count     (error_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Count cycles in which nothing at all moves.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_results);
        $display("throughput_meter_moving_average_core_tb: FAIL");
        $finish;
    end

    // Result side: random stalls, and a long hold-off whenever one is asked for.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_served != hold_requests) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (RECV_HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
            IDLE_BOTH:     begin sender_idle_pct = 22; receiver_stall_pct = 22; end
        endcase
    endtask

    // Mostly ordinary frame sizes, with the extremes mixed in.
    function automatic logic [23:0] frame_size();
        case ($urandom_range(0, 9))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2, 3:    return 24'($urandom_range(0, 1500));
            default: return 24'($urandom);
        endcase
    endfunction

    // Offer one request after any idle gap and hold it until it is taken.
    task automatic send_request(input logic op, input logic [23:0] bytes);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= bytes;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        requests_sent++;
        if (op == OP_TICK) ticks_sent++;
    endtask

    // Stop offering requests until every predicted result has been delivered.
    task automatic await_results();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic reconfigure(input logic [15:0] interval_val, input logic [6:0] window_val);
        await_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INTERVAL;
        cfg_wdata <= interval_val;
        @(negedge aclk);
        cfg_index <= CFG_WINDOW;
        cfg_wdata <= 16'(window_val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // One random phase under a given setting and idling pattern.
    task automatic run_phase(input logic [15:0] interval_val, input logic [6:0] window_val,
                             input idle_mode_t mode, input int items, input int tick_pct,
                             input bit hold);
        reconfigure(interval_val, window_val);
        set_idle(mode);
        if (hold) hold_requests++;
        for (int i = 0; i < items; i++) begin
            // Halfway through, let the block drain completely.
            if (i == items / 2) await_results();
            if ($urandom_range(0, 99) < tick_pct) begin
                send_request(OP_TICK, 24'($urandom));
            end else begin
                send_request(OP_FRAME, frame_size());
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_INTERVAL;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_FRAME;
        set_idle(IDLE_NONE);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset settings, an empty first interval, field extremes.
        send_request(OP_TICK, 24'hFFFFFF);
        send_request(OP_FRAME, 24'd0);
        send_request(OP_FRAME, 24'hFFFFFF);
        send_request(OP_FRAME, 24'hAAAAAA);
        send_request(OP_FRAME, 24'h555555);
        send_request(OP_TICK, 24'd0);

        // Shortest interval with large frames drives the rate into saturation.
        reconfigure(16'd1, 7'd0);
        repeat (10) send_request(OP_FRAME, 24'hFFFFFF);
        send_request(OP_TICK, 24'd0);

        // Interval of zero, and a switch from cumulative to a short window that wraps.
        reconfigure(16'd0, 7'd3);
        send_request(OP_FRAME, 24'd12345);
        repeat (4) send_request(OP_TICK, 24'd0);

        // Longest interval with a window beyond the store, then a single-slot window.
        reconfigure(16'hFFFF, 7'd127);
        send_request(OP_FRAME, 24'hFFFFFF);
        send_request(OP_TICK, 24'd0);
        reconfigure(16'd1000, 7'd1);
        send_request(OP_TICK, 24'd0);

        // Random phases over a range of settings and idling patterns.
        run_phase(16'd1000, 7'd0, IDLE_NONE, 300, 12, 1'b0);
        run_phase(16'd1, 7'd64, IDLE_SENDER, 300, 50, 1'b0);
        run_phase(16'hFFFF, 7'd5, IDLE_RECEIVER, 200, 20, 1'b0);
        run_phase(16'($urandom_range(1, 65535)), 7'd0, IDLE_BOTH, 200, 15, 1'b0);
        run_phase(16'($urandom_range(1, 20)), 7'd100, IDLE_NONE, 200, 25, 1'b1);
        run_phase(16'd0, 7'd1, IDLE_RECEIVER, 150, 20, 1'b0);
        run_phase(16'($urandom_range(1, 65535)), 7'($urandom_range(1, 64)), IDLE_BOTH,
                  200, 15, 1'b0);
        run_phase(16'($urandom_range(1, 65535)), 7'd64, IDLE_NONE, 100, 30, 1'b0);

        await_results();
        repeat (END_CYCLES) @(negedge aclk);

        $display("Run covered %0d requests (%0d ticks) under %0d register settings;",
                 requests_sent, ticks_sent, settings_applied);
        $display("%0d results compared over both mean modes, oversized windows, %s",
                 results_checked, "intervals 0/1/65535, rate saturation and a long hold-off.");
        if (error_count == 0) begin
            $display("throughput_meter_moving_average_core_tb: PASS");
        end else begin
            $display("throughput_meter_moving_average_core_tb: FAIL");
        end
        $finish;
    end

endmodule
